// File: design/itrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrs_pkg
// Shared types, constants and the symbol lookup for the radix text renderer.
// ----------------------------------------------------------------------------
package itrs_pkg;

    localparam int MAX_RADIX = 16;
    localparam int RAD_W     = $clog2(MAX_RADIX) + 1;
    localparam int DIG_W     = $clog2(MAX_RADIX);
    localparam int VAL_W     = 32;
    localparam int MAX_DIGS  = VAL_W;
    localparam int CNT_W     = $clog2(MAX_DIGS) + 1;
    localparam int SYM_W     = 8;
    localparam int TAB_W     = MAX_RADIX * SYM_W;
    localparam int IDX_W     = 2;
    localparam int QAW       = 1;
    localparam int QDEPTH    = 1 << QAW;

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

    localparam logic [IDX_W-1:0] REG_RADIX    = 2'd0;
    localparam logic [IDX_W-1:0] REG_SYM_LOW  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SYM_HIGH = 2'd2;

    typedef struct packed {
        logic             neg;
        logic [VAL_W-1:0] mag;
    } t_job;

    function automatic logic [SYM_W-1:0] sym_of(input logic [TAB_W-1:0] tab,
                                                 input logic [DIG_W-1:0] digit);
        sym_of = tab[{digit, 3'b000} +: SYM_W];
    endfunction

endpackage

// File: design/integer_to_radix_symbols.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_symbols
// Renders a signed 32-bit value as text in a configured radix (2..16),
// most significant symbol first, with a leading '-' for negative values.
//
// channel   direction  handshake                      payload
// input     in         start & !busy                  i_value
// config    in         i_cfg_valid & o_cfg_ready      i_cfg_index, i_cfg_data
// result    out        o_valid (one cycle, no stall)  o_symbol, o_last
//
// Each digit takes one pass of the shared divide-by-radix unit (8 quotient
// bits a cycle) and then an emit step; a negative item adds a sign step, and
// every item starts with a job fetch. The back fetches the next job only
// after the last symbol of the current one has been emitted.
// A two-entry job queue lets the input side run ahead of the divider.
// Synchronous reset clears the alphabet to radix 0; no clearing pass.
// An invalid alphabet drops the item without a result.
// ----------------------------------------------------------------------------
module integer_to_radix_symbols (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [itrs_pkg::VAL_W-1:0] i_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [itrs_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [63:0]                       i_cfg_data,
    output logic                              o_valid,
    output logic [itrs_pkg::SYM_W-1:0]        o_symbol,
    output logic                              o_last
);

    itrs_pkg::t_job             push_job;
    itrs_pkg::t_job             head_job;
    logic                       push;
    logic                       pop;
    logic                       q_full;
    logic                       q_empty;
    logic [itrs_pkg::RAD_W-1:0] radix;
    logic [itrs_pkg::TAB_W-1:0] tab;

    itrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job),
        .o_radix     (radix),
        .o_tab       (tab)
    );

    itrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    itrs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_job    (head_job),
        .o_pop    (pop),
        .i_radix  (radix),
        .i_tab    (tab),
        .o_valid  (o_valid),
        .o_symbol (o_symbol),
        .o_last   (o_last)
    );

endmodule

// File: design/itrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrs_front
// Holds the alphabet registers, checks the alphabet and turns each accepted
// value into a sign and magnitude job for the queue.
// ----------------------------------------------------------------------------
module itrs_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [itrs_pkg::VAL_W-1:0] i_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [itrs_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [63:0]                       i_cfg_data,
    input  logic                              i_q_full,
    output logic                              o_push,
    output itrs_pkg::t_job                    o_job,
    output logic [itrs_pkg::RAD_W-1:0]        o_radix,
    output logic [itrs_pkg::TAB_W-1:0]        o_tab
);

    logic [itrs_pkg::RAD_W-1:0] r_radix;
    logic [63:0]                r_sym_low;
    logic [63:0]                r_sym_high;
    logic [itrs_pkg::TAB_W-1:0] tab;
    logic                       alpha_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= '0;
            r_sym_low  <= '0;
            r_sym_high <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                itrs_pkg::REG_RADIX:    r_radix    <= i_cfg_data[itrs_pkg::RAD_W-1:0];
                itrs_pkg::REG_SYM_LOW:  r_sym_low  <= i_cfg_data;
                itrs_pkg::REG_SYM_HIGH: r_sym_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign tab = {r_sym_high, r_sym_low};

    always_comb begin
        logic [itrs_pkg::SYM_W-1:0] s;
        alpha_ok = (r_radix >= itrs_pkg::RAD_W'(2)) &&
                   (r_radix <= itrs_pkg::RAD_W'(itrs_pkg::MAX_RADIX));
        for (int i = 0; i < itrs_pkg::MAX_RADIX; i++) begin
            s = itrs_pkg::sym_of(tab, itrs_pkg::DIG_W'(i));
            if (itrs_pkg::RAD_W'(i) < r_radix) begin
                if (s == itrs_pkg::SYM_PLUS || s == itrs_pkg::SYM_MINUS) begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < itrs_pkg::MAX_RADIX; j++) begin
                    if (itrs_pkg::RAD_W'(j) < r_radix &&
                        itrs_pkg::sym_of(tab, itrs_pkg::DIG_W'(j)) == s) begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign busy      = i_q_full;
    assign o_push    = start && !i_q_full && alpha_ok;
    assign o_job.neg = i_value[itrs_pkg::VAL_W-1];
    assign o_job.mag = i_value[itrs_pkg::VAL_W-1] ? (~i_value + 1'b1) : i_value;
    assign o_radix   = r_radix;
    assign o_tab     = tab;

endmodule

// File: design/itrs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrs_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module itrs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itrs_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output itrs_pkg::t_job o_job,
    output logic           o_empty
);

    itrs_pkg::t_job               r_mem [itrs_pkg::QDEPTH];
    logic [itrs_pkg::QAW-1:0]     r_wr_ptr;
    logic [itrs_pkg::QAW-1:0]     r_rd_ptr;
    logic [itrs_pkg::QAW:0]       r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_count == (itrs_pkg::QAW+1)'(itrs_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/itrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrs_back
// Divides the magnitude by the radix eight bits a cycle, stacks the digits
// and emits the sign and the digit symbols most significant first.
// ----------------------------------------------------------------------------
module itrs_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  itrs_pkg::t_job             i_job,
    output logic                       o_pop,
    input  logic [itrs_pkg::RAD_W-1:0] i_radix,
    input  logic [itrs_pkg::TAB_W-1:0] i_tab,
    output logic                       o_valid,
    output logic [itrs_pkg::SYM_W-1:0] o_symbol,
    output logic                       o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                 r_state;
    logic [itrs_pkg::VAL_W-1:0] r_work;
    logic [itrs_pkg::DIG_W-1:0] r_rem;
    logic [1:0]                 r_step;
    logic                       r_neg;
    logic [itrs_pkg::CNT_W-1:0] r_cnt;
    logic [itrs_pkg::DIG_W-1:0] r_digit [itrs_pkg::MAX_DIGS];
    logic                       r_valid;
    logic [itrs_pkg::SYM_W-1:0] r_symbol;
    logic                       r_last;

    logic [itrs_pkg::DIG_W-1:0] n_rem;
    logic [7:0]                 n_qbyte;
    logic [itrs_pkg::VAL_W-1:0] n_work;
    logic [itrs_pkg::CNT_W-2:0] top_idx;

    always_comb begin
        logic [itrs_pkg::DIG_W:0]   t;
        logic [itrs_pkg::DIG_W-1:0] rem;
        rem     = r_rem;
        n_qbyte = '0;
        for (int b = 0; b < 8; b++) begin
            t = {rem, r_work[itrs_pkg::VAL_W-1-b]};
            if (t >= i_radix) begin
                n_qbyte[7-b] = 1'b1;
                t            = t - i_radix;
            end
            rem = t[itrs_pkg::DIG_W-1:0];
        end
        n_rem = rem;
    end

    assign n_work  = {r_work[itrs_pkg::VAL_W-9:0], n_qbyte};
    assign top_idx = r_cnt[itrs_pkg::CNT_W-2:0] - 1'b1;
    assign o_pop   = (r_state == ST_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && r_step == 2'd3) begin
            r_digit[r_cnt[itrs_pkg::CNT_W-2:0]] <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
            r_rem   <= '0;
            r_neg   <= 1'b0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_work  <= i_job.mag;
                        r_neg   <= i_job.neg;
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_work <= n_work;
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd3) begin
                        r_rem <= '0;
                        r_cnt <= r_cnt + 1'b1;
                        if (n_work == '0) begin
                            r_state <= r_neg ? ST_SIGN : ST_EMIT;
                        end
                    end else begin
                        r_rem <= n_rem;
                    end
                end
                ST_SIGN: begin
                    r_valid  <= 1'b1;
                    r_symbol <= itrs_pkg::SYM_MINUS;
                    r_state  <= ST_EMIT;
                end
                ST_EMIT: begin
                    r_valid  <= 1'b1;
                    r_symbol <= itrs_pkg::sym_of(i_tab, r_digit[top_idx]);
                    r_last   <= (r_cnt == itrs_pkg::CNT_W'(1));
                    r_cnt    <= r_cnt - 1'b1;
                    if (r_cnt == itrs_pkg::CNT_W'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last without valid");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= itrs_pkg::CNT_W'(itrs_pkg::MAX_DIGS))
        else $error("digit count out of range");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> ({1'b0, r_rem} < i_radix))
        else $error("remainder not below radix");

    a_emit_from: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == ST_SIGN || $past(r_state) == ST_EMIT))
        else $error("symbol outside emit phase");

    a_emit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_cnt != '0))
        else $error("emit with empty digit stack");

endmodule

// File: test/radix_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_text_checker
// Watches the value, register and symbol channels of the radix text renderer.
// Keeps its own copy of the alphabet registers, renders every accepted value
// into the symbols it should produce, and compares each emitted symbol and
// its last flag against the oldest symbol still owed. Reports the number of
// mismatches and the number of symbols still owed.
// ----------------------------------------------------------------------------
module radix_text_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [itrs_pkg::VAL_W-1:0] i_value,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [itrs_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                i_cfg_data,
    input  logic                       i_valid,
    input  logic [itrs_pkg::SYM_W-1:0] i_symbol,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_pending
);
    import itrs_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } glyph_t;

    logic [4:0]       radix_reg;
    logic [TAB_W-1:0] sym_table;
    glyph_t           owed_glyphs[$];
    glyph_t           oldest;
    int               fail_count;

    assign o_fail_count = fail_count;

    initial begin
        fail_count = 0;
        radix_reg  = '0;
        sym_table  = '0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic bit alphabet_ok();
        logic [SYM_W-1:0] s;
        if (radix_reg < 2 || radix_reg > MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < radix_reg; i++) begin
            s = sym_table[i*SYM_W +: SYM_W];
            if (s == SYM_PLUS || s == SYM_MINUS)
                return 1'b0;
            for (int j = i + 1; j < radix_reg; j++)
                if (sym_table[j*SYM_W +: SYM_W] == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic render_value(input logic [VAL_W-1:0] raw);
        logic             negative;
        logic [VAL_W-1:0] mag;
        logic [3:0]       digits [0:MAX_DIGS-1];
        int               nd;
        if (!alphabet_ok())
            return;
        negative = raw[VAL_W-1];
        mag = negative ? (32'd0 - raw) : raw;
        nd = 0;
        do begin
            digits[nd] = 4'(mag % radix_reg);
            nd++;
            mag = mag / radix_reg;
        end while (mag != 0);
        if (negative)
            owed_glyphs.push_back('{symbol: SYM_MINUS, last: 1'b0});
        for (int k = nd - 1; k >= 0; k--)
            owed_glyphs.push_back('{symbol: sym_table[digits[k]*SYM_W +: SYM_W],
                                    last: (k == 0)});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_reg = '0;
            sym_table = '0;
            owed_glyphs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_RADIX:    radix_reg = i_cfg_data[4:0];
                    REG_SYM_LOW:  sym_table[63:0] = i_cfg_data;
                    REG_SYM_HIGH: sym_table[127:64] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                render_value(i_value);
            if (i_valid) begin
                if (owed_glyphs.size() == 0) begin
                    report_mismatch($sformatf("unexpected symbol %h last %b",
                                              i_symbol, i_last));
                end else begin
                    oldest = owed_glyphs.pop_front();
                    if (i_symbol !== oldest.symbol)
                        report_mismatch($sformatf("symbol %h, want %h",
                                                  i_symbol, oldest.symbol));
                    if (i_last !== oldest.last)
                        report_mismatch($sformatf("last %b, want %b on symbol %h",
                                                  i_last, oldest.last, oldest.symbol));
                end
            end
        end
        o_pending <= owed_glyphs.size();
    end

endmodule

// File: test/integer_to_radix_symbols_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_symbols_tb
// Drives the radix text renderer with directed corner values and alphabets
// (extreme integers, radix 2 and 16, zero-byte symbols, every kind of bad
// alphabet), then with random alphabets and random values under random
// sender gaps. A separate checker predicts and compares every symbol.
// ----------------------------------------------------------------------------
module integer_to_radix_symbols_tb;
    import itrs_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam int               DRAIN_WAIT  = 200;
    localparam int               VALID_ITEMS = 180;

    localparam logic [63:0] DEC_LOW    = 64'h3736_3534_3332_3130;
    localparam logic [63:0] DEC_HIGH   = 64'h4645_4443_4241_3938;
    localparam logic [63:0] RAW_LOW    = 64'h0706_0504_0302_0100;
    localparam logic [63:0] RAW_HIGH   = 64'h0F0E_0D0C_0B0A_0908;
    localparam logic [63:0] PLUS_HIGH  = 64'h2B45_4443_4241_3938;
    localparam logic [63:0] MINUS_LOW  = 64'h3736_3534_3332_312D;
    localparam logic [63:0] DUP_HIGH   = 64'h4545_4443_4241_3938;
    localparam logic [63:0] SPARE_HIGH = 64'h2B2B_2D43_3939_3938;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [VAL_W-1:0]   i_value = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index = '0;
    logic [63:0]        i_cfg_data = '0;
    logic               o_valid;
    logic [SYM_W-1:0]   o_symbol;
    logic               o_last;
    int                 fail_count;
    int                 pending;

    always #5 i_clk = ~i_clk;

    integer_to_radix_symbols dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_symbol    (o_symbol),
        .o_last      (o_last)
    );

    radix_text_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (i_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (o_valid),
        .i_symbol     (o_symbol),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            5: begin
                v = $urandom_range(0, 300);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            6: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            7, 8, 9: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_alphabet(input logic [4:0] rdx, input logic [63:0] low,
                                 input logic [63:0] high);
        logic [63:0] d;
        d = {$urandom, $urandom};
        d[4:0] = rdx;
        write_reg(REG_RADIX, d);
        write_reg(REG_SYM_LOW, low);
        write_reg(REG_SYM_HIGH, high);
    endtask

    task automatic send_value(input logic [VAL_W-1:0] v, input bit no_gaps);
        int gap;
        start   <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic settle();
        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic make_alphabet(input bit want_valid, output logic [4:0] rdx,
                                 output logic [TAB_W-1:0] tab);
        bit [255:0]       used;
        logic [SYM_W-1:0] b;
        int               i;
        int               j;
        int               mode;
        tab  = {$urandom, $urandom, $urandom, $urandom};
        used = '0;
        mode = want_valid ? 4 : $urandom_range(0, 3);
        case (mode)
            0: rdx = $urandom_range(0, 1);
            1: rdx = $urandom_range(MAX_RADIX + 1, 31);
            default: begin
                case ($urandom_range(0, 3))
                    0: rdx = 2;
                    1: rdx = MAX_RADIX;
                    default: rdx = $urandom_range(2, MAX_RADIX);
                endcase
            end
        endcase
        if (mode >= 2) begin
            for (i = 0; i < rdx; i++) begin
                do b = $urandom_range(0, 255);
                while (b == SYM_PLUS || b == SYM_MINUS || used[b]);
                used[b] = 1'b1;
                tab[i*SYM_W +: SYM_W] = b;
            end
        end
        if (mode == 2) begin
            i = $urandom_range(0, rdx - 1);
            tab[i*SYM_W +: SYM_W] = $urandom_range(0, 1) ? SYM_PLUS : SYM_MINUS;
        end else if (mode == 3) begin
            j = $urandom_range(1, rdx - 1);
            i = $urandom_range(0, j - 1);
            tab[j*SYM_W +: SYM_W] = tab[i*SYM_W +: SYM_W];
        end
    endtask

    initial begin
        logic [4:0]       rdx;
        logic [TAB_W-1:0] tab;
        bit               bad;
        bit               burst;
        int               n;
        int               pause_at;
        int               valid_sent;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset alphabet is empty: drop items
        send_value(32'd12345, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b0);

        settle();
        load_alphabet(5'd10, DEC_LOW, DEC_HIGH);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        send_value(32'd0, 1'b0);
        send_value(32'd7, 1'b0);
        send_value(32'hFFFF_FFFF, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'h8000_0000, 1'b0);
        wait_for_drain();
        send_value(32'd1000, 1'b0);

        settle();
        load_alphabet(5'd2, DEC_LOW, DEC_HIGH);
        send_value(32'h8000_0000, 1'b1);
        send_value(32'h7FFF_FFFF, 1'b1);
        send_value(32'd0, 1'b1);
        send_value(32'hFFFF_FFFF, 1'b1);

        settle();
        load_alphabet(5'd16, DEC_LOW, DEC_HIGH);
        send_value(32'hDEAD_BEEF, 1'b0);
        send_value(32'h7FFF_FFFF, 1'b0);
        send_value(32'd255, 1'b0);

        // zero byte as a symbol
        settle();
        load_alphabet(5'd16, RAW_LOW, RAW_HIGH);
        send_value(32'd0, 1'b0);
        send_value(-32'sd300, 1'b0);

        settle();
        load_alphabet(5'd1, DEC_LOW, DEC_HIGH);
        send_value(32'd5, 1'b0);
        settle();
        load_alphabet(5'd17, DEC_LOW, DEC_HIGH);
        send_value(32'd5, 1'b0);
        settle();
        load_alphabet(5'd16, DEC_LOW, PLUS_HIGH);
        send_value(32'd77, 1'b0);
        settle();
        load_alphabet(5'd16, MINUS_LOW, DEC_HIGH);
        send_value(32'd77, 1'b0);
        settle();
        load_alphabet(5'd16, DEC_LOW, DUP_HIGH);
        send_value(32'd77, 1'b0);

        // sign and duplicate symbols past the radix are unused
        settle();
        load_alphabet(5'd10, DEC_LOW, SPARE_HIGH);
        send_value(-32'sd98765, 1'b0);

        valid_sent = 0;
        while (valid_sent < VALID_ITEMS) begin
            settle();
            bad = ($urandom_range(0, 5) == 0);
            make_alphabet(!bad, rdx, tab);
            load_alphabet(rdx, tab[63:0], tab[127:64]);
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNUSED, {$urandom, $urandom});
            n        = bad ? 5 : $urandom_range(10, 30);
            burst    = ($urandom_range(0, 3) == 0);
            pause_at = $urandom_range(1, n - 1);
            for (int i = 0; i < n; i++) begin
                if (i == pause_at && $urandom_range(0, 1))
                    wait_for_drain();
                send_value(rand_value(), burst);
                if (!bad)
                    valid_sent++;
            end
        end

        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
